### design/tepq_pkg.sv
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared codes and types for the timed event priority queue.
// ----------------------------------------------------------------------------
package tepq_pkg;

   localparam int OPCODE_BITS  = 2;
   localparam int STATUS_BITS  = 2;
   localparam int ARRIVAL_BITS = 32;

   localparam logic [OPCODE_BITS-1:0] OP_SEND   = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_POP    = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_POPPED  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_NOTHING = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_FULL    = 2'd3;

   typedef struct packed {
      logic clear;    // drop the current best, start a new sweep
      logic sample;   // entry on the read port is live and valid
   } scan_ctl_type;

endpackage

### design/tepq_scan.sv
// ----------------------------------------------------------------------------
// tepq_scan
// Sweep tracker: keeps the earliest entry seen (deadline, then arrival).
// ----------------------------------------------------------------------------
module tepq_scan #(
   parameter int TIME_BITS   = 48,
   parameter int HANDLE_BITS = 16,
   parameter int IDX_BITS    = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tepq_pkg::scan_ctl_type            ctl,
   input  logic [TIME_BITS-1:0]              ent_deadline,
   input  logic [tepq_pkg::ARRIVAL_BITS-1:0] ent_arrival,
   input  logic [HANDLE_BITS-1:0]            ent_payload,
   input  logic [IDX_BITS-1:0]               ent_idx,
   output logic                              best_found,
   output logic [TIME_BITS-1:0]              best_deadline,
   output logic [tepq_pkg::ARRIVAL_BITS-1:0] best_arrival,
   output logic [HANDLE_BITS-1:0]            best_payload,
   output logic [IDX_BITS-1:0]               best_idx
);

   logic                              found_ff, found_in;
   logic [TIME_BITS-1:0]              dl_ff;
   logic [tepq_pkg::ARRIVAL_BITS-1:0] arr_ff;
   logic [HANDLE_BITS-1:0]            pay_ff;
   logic [IDX_BITS-1:0]               idx_ff;
   logic                              take;

   always_comb begin
      take = ctl.sample && (!found_ff || (ent_deadline < dl_ff) ||
             ((ent_deadline == dl_ff) && (ent_arrival < arr_ff)));
      if (ctl.clear) begin
         found_in = 1'b0;
      end else begin
         found_in = found_ff || take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !ctl.clear) begin
         dl_ff  <= ent_deadline;
         arr_ff <= ent_arrival;
         pay_ff <= ent_payload;
         idx_ff <= ent_idx;
      end
   end

   assign best_found    = found_ff;
   assign best_deadline = dl_ff;
   assign best_arrival  = arr_ff;
   assign best_payload  = pay_ff;
   assign best_idx      = idx_ff;

endmodule

### design/timed_event_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// timed_event_priority_queue_unit
// Store of timed signals; pops the earliest due one, ties by arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_* and raise start; the beat is taken on a rising edge
//   where start is high and busy is low. Opcodes: send, pop, delete all.
//   Output: one result per beat, shown on rsp_* for exactly one cycle while
//   rsp_strobe is high. The receiver cannot stall; it must take it then.
//   Timing: delete, refused send, and a pop with nothing due answer in the
//   next cycle and leave busy low. An accepted send answers in the next
//   cycle, then holds busy while the free-slot pointer walks the valid bits
//   upward. A successful pop sweeps the entry RAM one address a cycle
//   through one read port to find the new head and answers once the sweep
//   is done, busy throughout.
//   Reset: synchronous; empties the store and clears the arrival counter.
//   Head and entry RAM contents are not cleared; count and valid bits guard them.
// ----------------------------------------------------------------------------
module timed_event_priority_queue_unit #(
   parameter int CAPACITY    = 64,
   parameter int TIME_BITS   = 48,
   parameter int HANDLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tepq_pkg::OPCODE_BITS-1:0]   req_opcode,
   input  logic [TIME_BITS-1:0]               req_deadline,
   input  logic [HANDLE_BITS-1:0]             req_payload_handle,
   input  logic [TIME_BITS-1:0]               req_current_time,
   output logic                               rsp_strobe,
   output logic [tepq_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [HANDLE_BITS-1:0]             rsp_popped_payload,
   output logic [TIME_BITS-1:0]               rsp_next_deadline,
   output logic                               rsp_none_pending,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_occupancy
);

   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int ARR_BITS   = tepq_pkg::ARRIVAL_BITS;
   localparam int ENTRY_BITS = TIME_BITS + ARR_BITS + HANDLE_BITS;
   localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [ENTRY_BITS-1:0] entry_mem [CAPACITY];

   logic [1:0]             state_ff, state_in;
   logic [CAPACITY-1:0]    valid_ff, valid_in;
   logic [CNT_BITS-1:0]    pending_ff, pending_in;
   logic [ARR_BITS-1:0]    counter_ff, counter_in;
   logic [CNT_BITS-1:0]    free_ff, free_in;
   logic [CNT_BITS-1:0]    walk_ff, walk_in;
   logic [CNT_BITS-1:0]    scan_ff, scan_in;
   logic [TIME_BITS-1:0]   head_dl_ff, head_dl_in;
   logic [ARR_BITS-1:0]    head_arr_ff, head_arr_in;
   logic [HANDLE_BITS-1:0] head_pay_ff, head_pay_in;
   logic [IDX_BITS-1:0]    head_idx_ff, head_idx_in;
   logic                   strobe_ff, strobe_in;
   logic [tepq_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [HANDLE_BITS-1:0] popped_ff, popped_in;
   logic                   samp_ff, samp_in;
   logic [IDX_BITS-1:0]    rd_idx_ff;
   logic [ENTRY_BITS-1:0]  rd_data_ff;

   logic                   accept;
   logic                   mem_we;
   logic                   mem_re;
   logic [IDX_BITS-1:0]    slot;
   logic [ENTRY_BITS-1:0]  mem_wd;
   logic                   new_wins;
   logic                   have_head;

   tepq_pkg::scan_ctl_type scan_ctl;
   logic                   best_found;
   logic [TIME_BITS-1:0]   best_deadline;
   logic [ARR_BITS-1:0]    best_arrival;
   logic [HANDLE_BITS-1:0] best_payload;
   logic [IDX_BITS-1:0]    best_idx;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign have_head = (pending_ff != '0);
   assign slot      = free_ff[IDX_BITS-1:0];
   assign mem_wd    = {req_deadline, counter_ff, req_payload_handle};
   assign new_wins  = !have_head || (req_deadline < head_dl_ff) ||
                      ((req_deadline == head_dl_ff) && (counter_ff < head_arr_ff));
   assign mem_re    = (state_ff == S_SCAN) && (scan_ff != CAP_CNT);

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      pending_in  = pending_ff;
      counter_in  = counter_ff;
      free_in     = free_ff;
      walk_in     = walk_ff;
      scan_in     = scan_ff;
      head_dl_in  = head_dl_ff;
      head_arr_in = head_arr_ff;
      head_pay_in = head_pay_ff;
      head_idx_in = head_idx_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      popped_in   = popped_ff;
      samp_in     = mem_re && valid_ff[scan_ff[IDX_BITS-1:0]];
      mem_we      = 1'b0;
      scan_ctl    = '{clear: 1'b0, sample: samp_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               status_in = tepq_pkg::STAT_DONE;
               popped_in = '0;
               case (req_opcode)
                  tepq_pkg::OP_SEND: begin
                     if (pending_ff == CAP_CNT) begin
                        status_in = tepq_pkg::STAT_FULL;
                     end else begin
                        mem_we         = 1'b1;
                        valid_in[slot] = 1'b1;
                        pending_in     = pending_ff + 1'b1;
                        counter_in     = counter_ff + 1'b1;
                        if (new_wins) begin
                           head_dl_in  = req_deadline;
                           head_arr_in = counter_ff;
                           head_pay_in = req_payload_handle;
                           head_idx_in = slot;
                        end
                        walk_in  = free_ff + 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  tepq_pkg::OP_POP: begin
                     if (!have_head || (head_dl_ff > req_current_time)) begin
                        status_in = tepq_pkg::STAT_NOTHING;
                     end else begin
                        strobe_in             = 1'b0;
                        status_in             = tepq_pkg::STAT_POPPED;
                        popped_in             = head_pay_ff;
                        valid_in[head_idx_ff] = 1'b0;
                        pending_in            = pending_ff - 1'b1;
                        if (CNT_BITS'(head_idx_ff) < free_ff) begin
                           free_in = CNT_BITS'(head_idx_ff);
                        end
                        scan_in        = '0;
                        scan_ctl.clear = 1'b1;
                        state_in       = S_SCAN;
                     end
                  end
                  tepq_pkg::OP_DELETE: begin
                     valid_in   = '0;
                     pending_in = '0;
                     counter_in = '0;
                     free_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (walk_ff == CAP_CNT || !valid_ff[walk_ff[IDX_BITS-1:0]]) begin
               free_in  = walk_ff;
               state_in = S_IDLE;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (scan_ff == CAP_CNT) begin
               state_in = S_FINISH;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_FINISH: begin
            head_dl_in  = best_deadline;
            head_arr_in = best_arrival;
            head_pay_in = best_payload;
            head_idx_in = best_idx;
            strobe_in   = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         pending_ff <= '0;
         counter_ff <= '0;
         free_ff    <= '0;
         walk_ff    <= '0;
         scan_ff    <= '0;
         strobe_ff  <= 1'b0;
         samp_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
         counter_ff <= counter_in;
         free_ff    <= free_in;
         walk_ff    <= walk_in;
         scan_ff    <= scan_in;
         strobe_ff  <= strobe_in;
         samp_ff    <= samp_in;
      end
   end

   always_ff @(posedge clock) begin
      head_dl_ff  <= head_dl_in;
      head_arr_ff <= head_arr_in;
      head_pay_ff <= head_pay_in;
      head_idx_ff <= head_idx_in;
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      rd_idx_ff   <= scan_ff[IDX_BITS-1:0];
   end

   // entry RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[slot] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[scan_ff[IDX_BITS-1:0]];
      end
   end

   tepq_scan #(
      .TIME_BITS   (TIME_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .ctl           (scan_ctl),
      .ent_deadline  (rd_data_ff[ENTRY_BITS-1 -: TIME_BITS]),
      .ent_arrival   (rd_data_ff[HANDLE_BITS +: ARR_BITS]),
      .ent_payload   (rd_data_ff[HANDLE_BITS-1:0]),
      .ent_idx       (rd_idx_ff),
      .best_found    (best_found),
      .best_deadline (best_deadline),
      .best_arrival  (best_arrival),
      .best_payload  (best_payload),
      .best_idx      (best_idx)
   );

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_popped_payload = popped_ff;
   assign rsp_next_deadline  = have_head ? head_dl_ff : '0;
   assign rsp_none_pending   = !have_head;
   assign rsp_occupancy      = pending_ff;

`ifndef SYNTHESIS
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      pending_ff == CNT_BITS'($countones(valid_ff)))
      else $error("pending count disagrees with valid bits");

   a_sweep_finds_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (best_found == have_head))
      else $error("sweep result disagrees with occupancy");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && status_ff == tepq_pkg::STAT_FULL) |-> (pending_ff == CAP_CNT))
      else $error("full status with free slots");

   a_free_slot_is_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && free_ff != CAP_CNT) |-> !valid_ff[free_ff[IDX_BITS-1:0]])
      else $error("free pointer names an occupied slot");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed event priority queue. A directed table
// covers the empty, extreme, tie and clear cases; random phases then fill,
// drain and churn the store with clustered deadlines. A behavioral copy of
// the queue predicts every reply, and each strobed reply is checked per field.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CAPACITY    = 64;
   localparam int TIME_BITS   = 48;
   localparam int HANDLE_BITS = 16;
   localparam int OCC_BITS    = $clog2(CAPACITY + 1);
   localparam int ITEM_TARGET = 1550;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_TAIL  = 80;

   localparam logic [tepq_pkg::OPCODE_BITS-1:0] OP_SPARE = 2'd3;

   typedef logic [TIME_BITS-1:0]   tick_type;
   typedef logic [HANDLE_BITS-1:0] handle_type;

   localparam tick_type TICK_MAX = '1;

   typedef struct packed {
      logic [tepq_pkg::OPCODE_BITS-1:0] opcode;
      tick_type                         deadline;
      handle_type                       handle;
      tick_type                         current_time;
   } timer_cmd_type;

   typedef struct packed {
      logic [tepq_pkg::STATUS_BITS-1:0] status;
      handle_type                       popped_payload;
      tick_type                         next_deadline;
      logic                             none_pending;
      logic [OCC_BITS-1:0]              occupancy;
   } timer_reply_type;

   typedef struct packed {
      timer_cmd_type   cmd;
      logic            fixed;
      timer_reply_type reply;
   } stim_row_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [tepq_pkg::OPCODE_BITS-1:0]  req_opcode;
   tick_type                          req_deadline;
   handle_type                        req_payload_handle;
   tick_type                          req_current_time;
   logic                              rsp_strobe;
   logic [tepq_pkg::STATUS_BITS-1:0]  rsp_status;
   handle_type                        rsp_popped_payload;
   tick_type                          rsp_next_deadline;
   logic                              rsp_none_pending;
   logic [OCC_BITS-1:0]               rsp_occupancy;

   // typed-in reply for table rows, travels with the beat
   logic             row_fixed;
   timer_reply_type  row_reply;

   // shadow of the queue
   bit [TIME_BITS-1:0]              slot_deadline [CAPACITY];
   bit [HANDLE_BITS-1:0]            slot_handle   [CAPACITY];
   bit [tepq_pkg::ARRIVAL_BITS-1:0] slot_arrival  [CAPACITY];
   bit                              slot_live     [CAPACITY];
   bit [tepq_pkg::ARRIVAL_BITS-1:0] arrival_seq;
   bit [TIME_BITS-1:0]              head_deadline;
   bit                              head_live;
   int                              live_count;

   timer_reply_type awaited_replies [$];
   int              fault_count;
   int              idle_cycles;
   bit              burst_mode;

   timed_event_priority_queue_unit #(
      .CAPACITY    (CAPACITY),
      .TIME_BITS   (TIME_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_deadline       (req_deadline),
      .req_payload_handle (req_payload_handle),
      .req_current_time   (req_current_time),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_popped_payload (rsp_popped_payload),
      .rsp_next_deadline  (rsp_next_deadline),
      .rsp_none_pending   (rsp_none_pending),
      .rsp_occupancy      (rsp_occupancy)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int earliest_slot();
      int best = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (slot_live[i] && (best < 0 || slot_deadline[i] < slot_deadline[best] ||
             (slot_deadline[i] == slot_deadline[best] &&
              slot_arrival[i] < slot_arrival[best])))
            best = i;
      end
      return best;
   endfunction

   task automatic advance_queue(input timer_cmd_type cmd, output timer_reply_type reply);
      int slot;
      reply = '0;
      reply.status = tepq_pkg::STAT_DONE;
      case (cmd.opcode)
         tepq_pkg::OP_SEND: begin
            slot = -1;
            for (int i = CAPACITY - 1; i >= 0; i--)
               if (!slot_live[i]) slot = i;
            if (slot < 0) begin
               reply.status = tepq_pkg::STAT_FULL;
            end else begin
               slot_live[slot]     = 1'b1;
               slot_deadline[slot] = cmd.deadline;
               slot_handle[slot]   = cmd.handle;
               slot_arrival[slot]  = arrival_seq;
               arrival_seq++;
               live_count++;
               if (!head_live || cmd.deadline < head_deadline) head_deadline = cmd.deadline;
               head_live = 1'b1;
            end
         end
         tepq_pkg::OP_POP: begin
            if (!head_live || head_deadline > cmd.current_time) begin
               reply.status = tepq_pkg::STAT_NOTHING;
            end else begin
               slot = earliest_slot();
               reply.status         = tepq_pkg::STAT_POPPED;
               reply.popped_payload = slot_handle[slot];
               slot_live[slot]      = 1'b0;
               live_count--;
               slot = earliest_slot();
               head_live     = (slot >= 0);
               head_deadline = (slot >= 0) ? slot_deadline[slot] : '0;
            end
         end
         tepq_pkg::OP_DELETE: begin
            for (int i = 0; i < CAPACITY; i++) slot_live[i] = 1'b0;
            arrival_seq   = '0;
            head_live     = 1'b0;
            head_deadline = '0;
            live_count    = 0;
         end
         default: ;
      endcase
      reply.next_deadline = head_live ? head_deadline : '0;
      reply.none_pending  = !head_live;
      reply.occupancy     = OCC_BITS'(live_count);
   endtask

   // accept/compare on the pre-edge values of every signal
   always @(posedge clock) begin : reply_check
      timer_cmd_type   taken;
      timer_reply_type want;
      timer_reply_type got;
      bit              moved;
      moved = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            taken = '{req_opcode, req_deadline, req_payload_handle, req_current_time};
            advance_queue(taken, want);
            if (row_fixed) want = row_reply;
            awaited_replies.push_back(want);
            moved = 1'b1;
         end
         if (rsp_strobe) begin
            moved = 1'b1;
            got = '{rsp_status, rsp_popped_payload, rsp_next_deadline,
                    rsp_none_pending, rsp_occupancy};
            if (awaited_replies.size() == 0) begin
               $error("unexpected reply beat: status %0d", got.status);
               fault_count++;
            end else begin
               want = awaited_replies.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fault_count++;
               end
               if (got.popped_payload !== want.popped_payload) begin
                  $error("popped_payload: expected %h, got %h",
                         want.popped_payload, got.popped_payload);
                  fault_count++;
               end
               if (got.next_deadline !== want.next_deadline) begin
                  $error("next_deadline: expected %h, got %h",
                         want.next_deadline, got.next_deadline);
                  fault_count++;
               end
               if (got.none_pending !== want.none_pending) begin
                  $error("none_pending: expected %0d, got %0d",
                         want.none_pending, got.none_pending);
                  fault_count++;
               end
               if (got.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                  fault_count++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic issue(input timer_cmd_type cmd, input logic fixed,
                        input timer_reply_type reply);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_opcode         <= cmd.opcode;
      req_deadline       <= cmd.deadline;
      req_payload_handle <= cmd.handle;
      req_current_time   <= cmd.current_time;
      row_fixed          <= fixed;
      row_reply          <= reply;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (awaited_replies.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic tick_type pick_tick(tick_type base, int spread);
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0:       return '0;
         1:       return TICK_MAX;
         2, 3:    return tick_type'({$urandom, $urandom});
         default: return tick_type'(base + tick_type'($urandom_range(0, spread)));
      endcase
   endfunction

   stim_row_type directed_rows [0:23] = '{
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     48'd0},        1'b1,
        '{tepq_pkg::STAT_NOTHING, 16'd0, 48'd0, 1'b1, 7'd0}},
      '{'{OP_SPARE,            TICK_MAX, 16'hFFFF,  TICK_MAX},     1'b1,
        '{tepq_pkg::STAT_DONE, 16'd0, 48'd0, 1'b1, 7'd0}},
      '{'{tepq_pkg::OP_SEND,   TICK_MAX, 16'hFFFF,  48'd0},        1'b1,
        '{tepq_pkg::STAT_DONE, 16'd0, TICK_MAX, 1'b0, 7'd1}},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     48'd0},        1'b1,
        '{tepq_pkg::STAT_NOTHING, 16'd0, TICK_MAX, 1'b0, 7'd1}},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     TICK_MAX - 48'd1}, 1'b1,
        '{tepq_pkg::STAT_NOTHING, 16'd0, TICK_MAX, 1'b0, 7'd1}},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     TICK_MAX},     1'b1,
        '{tepq_pkg::STAT_POPPED, 16'hFFFF, 48'd0, 1'b1, 7'd0}},
      '{'{tepq_pkg::OP_SEND,   48'd0,    16'd0,     TICK_MAX},     1'b1,
        '{tepq_pkg::STAT_DONE, 16'd0, 48'd0, 1'b0, 7'd1}},
      '{'{tepq_pkg::OP_POP,    TICK_MAX, 16'hFFFF,  48'd0},        1'b1,
        '{tepq_pkg::STAT_POPPED, 16'd0, 48'd0, 1'b1, 7'd0}},
      '{'{tepq_pkg::OP_SEND,   48'd100,  16'h00AA,  48'd0},        1'b0, '0},
      '{'{tepq_pkg::OP_SEND,   48'd100,  16'h5500,  48'd0},        1'b0, '0},
      '{'{tepq_pkg::OP_SEND,   48'd50,   16'h1234,  48'd0},        1'b0, '0},
      '{'{tepq_pkg::OP_SEND,   48'd200,  16'hA5A5,  48'd0},        1'b0, '0},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     48'd49},       1'b0, '0},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     48'd50},       1'b0, '0},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     48'd100},      1'b0, '0},
      '{'{OP_SPARE, 48'hAAAA_AAAA_AAAA, 16'h5A5A, 48'h5555_5555_5555}, 1'b0, '0},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     48'd100},      1'b0, '0},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     48'd150},      1'b0, '0},
      '{'{tepq_pkg::OP_DELETE, 48'd0,    16'd0,     48'd0},        1'b1,
        '{tepq_pkg::STAT_DONE, 16'd0, 48'd0, 1'b1, 7'd0}},
      '{'{tepq_pkg::OP_SEND,   48'd7,    16'h0001,  48'd0},        1'b0, '0},
      '{'{tepq_pkg::OP_SEND,   48'd7,    16'h0002,  48'd0},        1'b0, '0},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     TICK_MAX},     1'b0, '0},
      '{'{tepq_pkg::OP_DELETE, 48'h5555_5555_5555, 16'hAAAA, 48'hAAAA_AAAA_AAAA}, 1'b1,
        '{tepq_pkg::STAT_DONE, 16'd0, 48'd0, 1'b1, 7'd0}},
      '{'{tepq_pkg::OP_POP,    48'd0,    16'd0,     TICK_MAX},     1'b1,
        '{tepq_pkg::STAT_NOTHING, 16'd0, 48'd0, 1'b1, 7'd0}}
   };

   initial begin : stimulus
      timer_cmd_type cmd;
      tick_type      base;
      int            kind;
      int            span;
      int            r;
      int            issued;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_opcode         <= tepq_pkg::OP_SEND;
      req_deadline       <= '0;
      req_payload_handle <= '0;
      req_current_time   <= '0;
      row_fixed          <= 1'b0;
      row_reply          <= '0;
      burst_mode         = 1'b0;
      fault_count        = 0;
      idle_cycles        = 0;
      issued             = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].reply);
         if (directed_rows[i].cmd.opcode != OP_SPARE) issued++;
      end
      wait_drained();

      while (issued < ITEM_TARGET) begin
         kind       = $urandom_range(0, 3);
         span       = $urandom_range(40, 120);
         burst_mode = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0:       base = TICK_MAX - tick_type'($urandom_range(0, 200));
            1:       base = tick_type'($urandom_range(0, 1000));
            default: base = tick_type'({$urandom, $urandom});
         endcase
         if ($urandom_range(0, 2) == 0) wait_drained();
         for (int n = 0; n < span && issued < ITEM_TARGET; n++) begin
            r = $urandom_range(0, 99);
            cmd.deadline     = tick_type'({$urandom, $urandom});
            cmd.handle       = handle_type'($urandom);
            cmd.current_time = tick_type'({$urandom, $urandom});
            case (kind)
               0:       cmd.opcode = (r < 45) ? tepq_pkg::OP_SEND :
                                     (r < 90) ? tepq_pkg::OP_POP :
                                     (r < 95) ? tepq_pkg::OP_DELETE : OP_SPARE;
               1:       cmd.opcode = (r < 88) ? tepq_pkg::OP_SEND :
                                     (r < 96) ? tepq_pkg::OP_POP :
                                     (r < 97) ? tepq_pkg::OP_DELETE : OP_SPARE;
               2:       cmd.opcode = (r < 15) ? tepq_pkg::OP_SEND :
                                     (r < 95) ? tepq_pkg::OP_POP :
                                     (r < 97) ? tepq_pkg::OP_DELETE : OP_SPARE;
               default: cmd.opcode = (r < 50) ? tepq_pkg::OP_SEND :
                                     (r < 90) ? tepq_pkg::OP_POP :
                                     (r < 98) ? tepq_pkg::OP_DELETE : OP_SPARE;
            endcase
            if (cmd.opcode == tepq_pkg::OP_SEND) begin
               cmd.deadline = pick_tick(base, 48);
            end else if (cmd.opcode == tepq_pkg::OP_POP) begin
               if (kind == 2 && $urandom_range(0, 1) == 0)
                  cmd.current_time = TICK_MAX;
               else
                  cmd.current_time = pick_tick(base, 80);
            end
            issue(cmd, 1'b0, '0);
            if (cmd.opcode != OP_SPARE) issued++;
         end
      end

      burst_mode = 1'b0;
      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
